// File: rtl/s256_pkg.sv
// Shared types, constants and round-constant table for the SHA-256 stream hasher.
`default_nettype none

package s256_pkg;

   localparam int WordBits  = 32;
   localparam int BlockBits = 512;
   localparam int DigBits   = 256;
   localparam int PartBits  = 64;
   localparam int LenBits   = 64;

   localparam logic [5:0] FILL_FULL = 6'd63;  // byte put at this fill completes the block
   localparam logic [5:0] LEN_FILL  = 6'd56;  // length field goes in at this fill
   localparam logic [5:0] RND_LAST  = 6'd63;
   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [1:0] PART_LAST = 2'd3;

   // command from controller to datapath
   typedef struct packed {
      logic       put_byte;   // shift one byte into the block buffer
      logic       from_req;   // byte comes from the request beat
      logic       mark;       // byte is the pad marker, else zero
      logic       count;      // add the byte to the message length
      logic       put_len;    // shift the 64-bit length into the buffer
      logic       load;       // working variables <= chaining words
      logic       round;      // one compression round
      logic [5:0] rnd;        // round number
      logic       update;     // fold working variables into chaining words
      logic       final_blk;  // last block of the message: emit digest, restart
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [5:0] fill;
      logic       out_busy;
   } stat_type;

   function automatic logic [WordBits-1:0] init_word(input logic [2:0] idx);
      logic [WordBits-1:0] v;
      case (idx)
         3'd0:    v = 32'h6a09e667;
         3'd1:    v = 32'hbb67ae85;
         3'd2:    v = 32'h3c6ef372;
         3'd3:    v = 32'ha54ff53a;
         3'd4:    v = 32'h510e527f;
         3'd5:    v = 32'h9b05688c;
         3'd6:    v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic logic [WordBits-1:0] round_k(input logic [5:0] idx);
      logic [WordBits-1:0] v;
      case (idx)
         6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba1;
         6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: rtl/sha256_stream_hasher.sv
// Intake: each accepted beat with req_byte_valid set puts one byte; a full 64-byte block then
// holds the request side off through load, 64 rounds and the chaining update.
// After the last beat: up to 64 pad bytes, the length and one or two compressions,
// then four digest beats (a prior digest must drain first).
// The single round unit bounds throughput: no bytes are taken while a block is compressed.
// Reset (synchronous): initial hash values loaded, byte and bit counts cleared, no output.
`default_nettype none

module sha256_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_digest_part,
   output logic             rsp_part_last
);
   import s256_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   s256_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_byte_valid (req_byte_valid),
      .req_last_byte  (req_last_byte),
      .req_ready      (req_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   s256_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data_byte   (req_data_byte),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_part (rsp_digest_part),
      .rsp_part_last   (rsp_part_last)
   );

endmodule

`default_nettype wire

// File: rtl/s256_ctrl.sv
// Controller state machine: byte intake, padding sequence and compression rounds.
`default_nettype none

module s256_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_byte_valid,
   input  wire logic               req_last_byte,
   output logic                    req_ready,
   input  wire s256_pkg::stat_type stat,
   output s256_pkg::cmd_type       cmd
);
   import s256_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PAD    = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_ROUND  = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic       pad_active_ff, pad_active_in;  // message ended, padding in progress
   logic       pad_first_ff, pad_first_in;    // marker byte still to go
   logic       final_ff, final_in;            // block in flight carries the length

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      rnd_in        = rnd_ff;
      pad_active_in = pad_active_ff;
      pad_first_in  = pad_first_ff;
      final_in      = final_ff;
      cmd           = '0;
      cmd.rnd       = rnd_ff;
      cmd.final_blk = final_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_last_byte) begin
                  pad_active_in = 1'b1;
                  pad_first_in  = 1'b1;
                  state_in      = ST_PAD;
               end
               if (req_byte_valid) begin
                  cmd.put_byte = 1'b1;
                  cmd.from_req = 1'b1;
                  cmd.count    = 1'b1;
                  if (stat.fill == FILL_FULL) begin
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_PAD: begin
            if (pad_first_ff) begin
               cmd.put_byte = 1'b1;
               cmd.mark     = 1'b1;
               pad_first_in = 1'b0;
               if (stat.fill == FILL_FULL) begin
                  state_in = ST_LOAD;
               end
            end else if (stat.fill == LEN_FILL) begin
               cmd.put_len = 1'b1;
               final_in    = 1'b1;
               state_in    = ST_LOAD;
            end else begin
               cmd.put_byte = 1'b1;
               if (stat.fill == FILL_FULL) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == RND_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // final block waits until the previous digest has drained
            if (!(final_ff && stat.out_busy)) begin
               cmd.update = 1'b1;
               if (final_ff) begin
                  final_in      = 1'b0;
                  pad_active_in = 1'b0;
                  state_in      = ST_IDLE;
               end else if (pad_active_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rnd_ff        <= '0;
         pad_active_ff <= 1'b0;
         pad_first_ff  <= 1'b0;
         final_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rnd_ff        <= rnd_in;
         pad_active_ff <= pad_active_in;
         pad_first_ff  <= pad_first_in;
         final_ff      <= final_in;
      end
   end

   a_final_only_padding: assert property (@(posedge clock) disable iff (reset)
      final_ff |-> pad_active_ff)
      else $error("final block flagged outside padding");

   a_round_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == RND_LAST) |=> state_ff == ST_UPDATE)
      else $error("round sequence did not end in update");

   a_no_beat_when_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.from_req)
      else $error("request byte taken outside idle");

endmodule

`default_nettype wire

// File: rtl/s256_dp.sv
// Datapath: block shift buffer, message schedule, round logic, chaining words, digest output.
`default_nettype none

module s256_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire s256_pkg::cmd_type cmd,
   input  wire logic [7:0]        req_data_byte,
   output s256_pkg::stat_type     stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [63:0]            rsp_digest_part,
   output logic                   rsp_part_last
);
   import s256_pkg::*;

   function automatic logic [WordBits-1:0] ror(input logic [WordBits-1:0] x, input int n);
      logic [2*WordBits-1:0] t;
      t = {x, x} >> n;
      return t[WordBits-1:0];
   endfunction

   logic [BlockBits-1:0] blk_ff, blk_in;     // word 0 of the block sits at the top
   logic [5:0]           fill_ff, fill_in;
   logic [LenBits-1:0]   bits_ff, bits_in;
   logic [WordBits-1:0]  chain_ff [8];
   logic [WordBits-1:0]  chain_in [8];
   logic [WordBits-1:0]  wk_ff [8];
   logic [WordBits-1:0]  wk_in [8];
   logic [DigBits-1:0]   out_ff, out_in;
   logic [1:0]           part_ff, part_in;
   logic                 out_busy_ff, out_busy_in;

   logic [7:0]          put_val;
   logic [WordBits-1:0] w_cur, w_new, s0, s1;
   logic [WordBits-1:0] t1, t2, big1, big0, ch, maj;
   logic [DigBits-1:0]  digest;
   logic                rsp_beat;

   assign stat.fill     = fill_ff;
   assign stat.out_busy = out_busy_ff;

   assign rsp_valid       = out_busy_ff;
   assign rsp_digest_part = out_ff[DigBits-1 -: PartBits];
   assign rsp_part_last   = (part_ff == PART_LAST);
   assign rsp_beat        = rsp_valid && rsp_ready;

   // schedule window: top word is W[t], next ones W[t+1] ... W[t+15]
   assign w_cur = blk_ff[511:480];
   assign s0    = ror(blk_ff[479:448], 7) ^ ror(blk_ff[479:448], 18) ^ (blk_ff[479:448] >> 3);
   assign s1    = ror(blk_ff[63:32], 17) ^ ror(blk_ff[63:32], 19) ^ (blk_ff[63:32] >> 10);
   assign w_new = s1 + blk_ff[223:192] + s0 + w_cur;

   assign big1 = ror(wk_ff[4], 6) ^ ror(wk_ff[4], 11) ^ ror(wk_ff[4], 25);
   assign big0 = ror(wk_ff[0], 2) ^ ror(wk_ff[0], 13) ^ ror(wk_ff[0], 22);
   assign ch   = (wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]);
   assign maj  = (wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]);
   assign t1   = wk_ff[7] + big1 + ch + round_k(cmd.rnd) + w_cur;
   assign t2   = big0 + maj;

   assign put_val = cmd.from_req ? req_data_byte : (cmd.mark ? PAD_MARK : 8'h00);

   always_comb begin
      blk_in  = blk_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      if (cmd.put_byte) begin
         blk_in  = {blk_ff[BlockBits-9:0], put_val};
         fill_in = fill_ff + 6'd1;
      end else if (cmd.put_len) begin
         blk_in  = {blk_ff[BlockBits-LenBits-1:0], bits_ff};
         fill_in = fill_ff + 6'd8;
      end else if (cmd.round) begin
         blk_in = {blk_ff[BlockBits-WordBits-1:0], w_new};
      end
      if (cmd.count) begin
         bits_in = bits_ff + 64'd8;
      end else if (cmd.update && cmd.final_blk) begin
         bits_in = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         wk_in[i] = wk_ff[i];
      end
      if (cmd.load) begin
         for (int i = 0; i < 8; i++) begin
            wk_in[i] = chain_ff[i];
         end
      end else if (cmd.round) begin
         for (int i = 1; i < 8; i++) begin
            wk_in[i] = wk_ff[i-1];
         end
         wk_in[4] = wk_ff[3] + t1;
         wk_in[0] = t1 + t2;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         digest[DigBits-1-WordBits*i -: WordBits] = chain_ff[i] + wk_ff[i];
         chain_in[i] = chain_ff[i];
      end
      out_in      = out_ff;
      part_in     = part_ff;
      out_busy_in = out_busy_ff;
      if (rsp_beat) begin
         out_in  = {out_ff[DigBits-PartBits-1:0], {PartBits{1'b0}}};
         part_in = part_ff + 2'd1;
         if (part_ff == PART_LAST) begin
            out_busy_in = 1'b0;
         end
      end
      if (cmd.update) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = cmd.final_blk ? init_word(3'(i))
                                        : digest[DigBits-1-WordBits*i -: WordBits];
         end
         if (cmd.final_blk) begin
            out_in      = digest;
            part_in     = '0;
            out_busy_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      out_ff <= out_in;
      for (int i = 0; i < 8; i++) begin
         wk_ff[i] <= wk_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         bits_ff     <= '0;
         part_ff     <= '0;
         out_busy_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= init_word(3'(i));
         end
      end else begin
         fill_ff     <= fill_in;
         bits_ff     <= bits_in;
         part_ff     <= part_in;
         out_busy_ff <= out_busy_in;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   a_len_at_56: assert property (@(posedge clock) disable iff (reset)
      cmd.put_len |-> fill_ff == LEN_FILL)
      else $error("length inserted at wrong fill");

   a_load_full_block: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> fill_ff == 6'd0)
      else $error("compression started on a partial block");

   a_digest_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && cmd.final_blk) |-> !out_busy_ff)
      else $error("digest overwritten before it drained");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && part_ff == PART_LAST) |=> !out_busy_ff)
      else $error("output still busy after fourth part");

endmodule

`default_nettype wire
